>>> hw/rtl/apcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcc_pkg: alarm panel code controller definitions
// Types, phase and event codes, and reset values shared by the panel files.
// ----------------------------------------------------------------------------
package apcc_pkg;

  // panel phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_EXIT  = 3'd1;
  localparam logic [2:0] PH_WATCH = 3'd2;
  localparam logic [2:0] PH_ENTRY = 3'd3;
  localparam logic [2:0] PH_SIREN = 3'd4;

  // event kinds
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_BUTTON = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // button codes
  localparam logic [1:0] BTN_NONE = 2'd0;
  localparam logic [1:0] BTN_A    = 2'd1;
  localparam logic [1:0] BTN_B    = 2'd2;
  localparam logic [1:0] BTN_BOTH = 2'd3;

  // code digit positions, sequence A,B,A,B
  localparam logic [2:0] POS_1 = 3'd1;
  localparam logic [2:0] POS_2 = 3'd2;
  localparam logic [2:0] POS_3 = 3'd3;
  localparam logic [2:0] POS_4 = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_EXIT_TICKS  = 2'd0;
  localparam logic [1:0] REG_ENTRY_TICKS = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_MAX_TRIES   = 2'd3;

  // reset values
  localparam logic [15:0] RST_EXIT_TICKS  = 16'd100;
  localparam logic [15:0] RST_ENTRY_TICKS = 16'd400;
  localparam logic [9:0]  RST_THRESHOLD   = 10'd30;
  localparam logic [2:0]  RST_MAX_TRIES   = 3'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] buttons;
    logic [9:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       armed;
    logic       siren_on;
    logic [2:0] tries_left;
    logic [2:0] code_position;
  } out_item_t;

  typedef struct packed {
    logic [15:0] exit_ticks;
    logic [15:0] entry_ticks;
    logic [9:0]  motion_threshold;
    logic [2:0]  max_tries;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  position;
    logic [2:0]  tries;
    logic [15:0] count;
  } panel_state_t;

endpackage

>>> hw/rtl/apcc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcc_stream_if: valid/ready channel
// Carries one payload per transaction; source drives valid and data.
// ----------------------------------------------------------------------------
interface apcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/apcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apcc_step: panel state update
// Next panel state for one event: countdowns, code entry, tries and motion.
// ----------------------------------------------------------------------------
module apcc_step
  import apcc_pkg::*;
(
  input  panel_state_t cur,
  input  in_item_t     item,
  input  cfg_t         cfg,
  output panel_state_t nxt
);

  logic [15:0] count_inc;
  logic [15:0] limit;
  logic        count_done;
  logic [2:0]  tries_dec;
  logic [2:0]  tries_load;
  logic        wrong;
  logic        code_ok;

  // countdown compare; a zero delay register behaves like one
  assign count_inc  = cur.count + 16'd1;
  assign limit      = (cur.phase == PH_EXIT) ? cfg.exit_ticks : cfg.entry_ticks;
  assign count_done = (count_inc >= limit) || (count_inc == 16'd0);

  // try bookkeeping
  assign tries_dec  = (cur.tries != 3'd0) ? (cur.tries - 3'd1) : 3'd0;
  assign tries_load = (cfg.max_tries == 3'd0) ? 3'd1 : cfg.max_tries;

  // button decode against the A,B,A,B sequence
  always_comb begin
    wrong   = 1'b0;
    code_ok = 1'b0;
    unique case (item.buttons)
      BTN_NONE: ;
      BTN_BOTH: wrong = 1'b1;
      BTN_A:    wrong = !((cur.position == POS_1) || (cur.position == POS_3));
      BTN_B: begin
        if (cur.position == POS_4) code_ok = 1'b1;
        else if (cur.position != POS_2) wrong = 1'b1;
      end
      default: ;
    endcase
  end

  // event handling
  always_comb begin
    nxt = cur;
    unique case (item.mode)
      MODE_TICK: begin
        if ((cur.phase == PH_EXIT) || (cur.phase == PH_ENTRY)) begin
          if (count_done) begin
            nxt.count = 16'd0;
            nxt.phase = (cur.phase == PH_EXIT) ? PH_WATCH : PH_SIREN;
          end else begin
            nxt.count = count_inc;
          end
        end
      end
      MODE_BUTTON: begin
        if (code_ok) begin
          nxt.phase    = (cur.phase == PH_IDLE) ? PH_EXIT : PH_IDLE;
          nxt.count    = 16'd0;
          nxt.position = POS_1;
          nxt.tries    = tries_load;
        end else if (wrong) begin
          nxt.position = POS_1;
          if (cur.phase != PH_IDLE) begin
            nxt.tries = tries_dec;
            if (tries_dec == 3'd0) nxt.phase = PH_SIREN;
          end
        end else if (item.buttons != BTN_NONE) begin
          nxt.position = cur.position + 3'd1;
        end
      end
      MODE_SAMPLE: begin
        if ((cur.phase == PH_WATCH) && (item.sample < cfg.motion_threshold)) begin
          nxt.phase = PH_ENTRY;
          nxt.count = 16'd0;
        end
      end
      MODE_NONE: ;
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/alarm_panel_code_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_panel_code_controller: security panel code and delay controller
// Takes ticks, button events and sensor samples, returns the panel status.
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  ---------+-----+---------------------------------------------------
//  in_chan  | in  | mode, buttons, sample: one event
//  out_chan | out | phase, armed, siren_on, tries_left, code_position
//  cfg_*    | in  | write of exit/entry ticks, threshold, max tries
//
//  one event per cycle; its status is in the output register on the next
//  cycle, set by the single state update between the panel state registers
//  a new event is taken whenever the output register is empty or being read
//  output stall holds the status and back-pressures the input
//  synchronous active-low reset: idle, position 1, tries 3, registers at
//  their defaults
// ----------------------------------------------------------------------------
module alarm_panel_code_controller
  import apcc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  apcc_stream_if.sink               in_chan,
  apcc_stream_if.source             out_chan,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [15:0]               cfg_wdata
);

  cfg_t         cfg_r;
  panel_state_t state_r;
  panel_state_t state_nxt;
  out_item_t    out_r;
  out_item_t    out_nxt;
  logic         out_valid_r;
  logic         accept;

  // handshake
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign accept         = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exit_ticks       <= RST_EXIT_TICKS;
      cfg_r.entry_ticks      <= RST_ENTRY_TICKS;
      cfg_r.motion_threshold <= RST_THRESHOLD;
      cfg_r.max_tries        <= RST_MAX_TRIES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXIT_TICKS:  cfg_r.exit_ticks       <= cfg_wdata;
        REG_ENTRY_TICKS: cfg_r.entry_ticks      <= cfg_wdata;
        REG_THRESHOLD:   cfg_r.motion_threshold <= cfg_wdata[9:0];
        REG_MAX_TRIES:   cfg_r.max_tries        <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // state update
  apcc_step u_step (
    .cur  (state_r),
    .item (in_chan.data),
    .cfg  (cfg_r),
    .nxt  (state_nxt)
  );

  // status from the updated state
  always_comb begin
    out_nxt.phase         = state_nxt.phase;
    out_nxt.armed         = (state_nxt.phase >= PH_WATCH);
    out_nxt.siren_on      = (state_nxt.phase == PH_SIREN);
    out_nxt.tries_left    = state_nxt.tries;
    out_nxt.code_position = state_nxt.position;
  end

  // panel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= PH_IDLE;
      state_r.position <= POS_1;
      state_r.tries    <= RST_MAX_TRIES;
      state_r.count    <= 16'd0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> test/alarm_panel_code_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_panel_code_checker: panel status predictor and comparator
// Follows the event and status channels and the register port, keeps its own
// copy of the panel state and registers, works out the status after every
// accepted event and compares each status transaction field by field.
// ----------------------------------------------------------------------------
module alarm_panel_code_checker
  import apcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending_results
);

  cfg_t         regs;
  panel_state_t panel;
  out_item_t    status_q[$];
  int           errors = 0;

  // a tries register of zero loads as one
  function automatic logic [2:0] reload_tries();
    return (regs.max_tries == 3'd0) ? 3'd1 : regs.max_tries;
  endfunction

  // wrong digit: costs a try unless idle, last try sounds the siren
  task automatic lose_try();
    if (panel.phase != PH_IDLE) begin
      if (panel.tries != 3'd0) panel.tries = panel.tries - 3'd1;
      if (panel.tries == 3'd0) panel.phase = PH_SIREN;
    end
    panel.position = POS_1;
  endtask

  // full code: idle arms via exit delay, anything else disarms
  task automatic code_complete();
    panel.phase    = (panel.phase == PH_IDLE) ? PH_EXIT : PH_IDLE;
    panel.count    = '0;
    panel.position = POS_1;
    panel.tries    = reload_tries();
  endtask

  // countdown runs only in exit and entry delay
  task automatic count_tick();
    logic [15:0] limit;
    if (panel.phase != PH_EXIT && panel.phase != PH_ENTRY) return;
    limit = (panel.phase == PH_EXIT) ? regs.exit_ticks : regs.entry_ticks;
    panel.count = panel.count + 16'd1;
    if (panel.count >= limit || panel.count == 16'd0) begin
      panel.count = '0;
      panel.phase = (panel.phase == PH_EXIT) ? PH_WATCH : PH_SIREN;
    end
  endtask

  // code sequence A,B,A,B
  task automatic press(input logic [1:0] btn);
    case (btn)
      BTN_NONE: ;
      BTN_BOTH: lose_try();
      BTN_A: begin
        if (panel.position == POS_1 || panel.position == POS_3)
          panel.position = panel.position + 3'd1;
        else
          lose_try();
      end
      default: begin
        if (panel.position == POS_2)      panel.position = POS_3;
        else if (panel.position == POS_4) code_complete();
        else                              lose_try();
      end
    endcase
  endtask

  task automatic apply_event(input in_item_t ev, output out_item_t st);
    case (ev.mode)
      MODE_TICK:   count_tick();
      MODE_BUTTON: press(ev.buttons);
      MODE_SAMPLE: begin
        if (panel.phase == PH_WATCH && ev.sample < regs.motion_threshold) begin
          panel.phase = PH_ENTRY;
          panel.count = '0;
        end
      end
      default: ;
    endcase
    st.phase         = panel.phase;
    st.armed         = (panel.phase >= PH_WATCH);
    st.siren_on      = (panel.phase == PH_SIREN);
    st.tries_left    = panel.tries;
    st.code_position = panel.position;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // status checked first: a status never belongs to an event of the same edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t seen;
    if (!rst_n) begin
      regs.exit_ticks       = RST_EXIT_TICKS;
      regs.entry_ticks      = RST_ENTRY_TICKS;
      regs.motion_threshold = RST_THRESHOLD;
      regs.max_tries        = RST_MAX_TRIES;
      panel.phase           = PH_IDLE;
      panel.position        = POS_1;
      panel.tries           = RST_MAX_TRIES;
      panel.count           = '0;
      status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen = out_data;
        if (status_q.size() == 0) begin
          $error("status transaction with none expected: phase %0d", seen.phase);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("phase", want.phase, seen.phase);
          check_field("armed", want.armed, seen.armed);
          check_field("siren_on", want.siren_on, seen.siren_on);
          check_field("tries_left", want.tries_left, seen.tries_left);
          check_field("code_position", want.code_position, seen.code_position);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_EXIT_TICKS:  regs.exit_ticks       = cfg_wdata;
          REG_ENTRY_TICKS: regs.entry_ticks      = cfg_wdata;
          REG_THRESHOLD:   regs.motion_threshold = cfg_wdata[9:0];
          default:         regs.max_tries        = cfg_wdata[2:0];
        endcase
      end
      if (in_valid && in_ready) begin
        apply_event(in_data, want);
        status_q.push_back(want);
      end
    end
    pending_results <= status_q.size();
    fail_count      <= errors;
  end

endmodule

>>> test/alarm_panel_code_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_panel_code_controller_tb: alarm panel code controller testbench
// Drives ticks, button events and sensor samples with random gaps and output
// stalls over several register settings, from directed corner cases to long
// random runs of codes, countdowns and motion; a checker compares every status.
// ----------------------------------------------------------------------------
module alarm_panel_code_controller_tb;
  import apcc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int ROUND_EVENTS = 140;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  bit          quiet;
  int          stall_left;
  int          idle_cycles;
  int          fail_count;
  int          pending_results;

  apcc_stream_if #(.payload_t(in_item_t))  event_chan ();
  apcc_stream_if #(.payload_t(out_item_t)) status_chan ();

  alarm_panel_code_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (event_chan),
    .out_chan  (status_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alarm_panel_code_checker status_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (event_chan.valid),
    .in_ready        (event_chan.ready),
    .in_data         (event_chan.data),
    .out_valid       (status_chan.valid),
    .out_ready       (status_chan.ready),
    .out_data        (status_chan.data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // status side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      status_chan.ready <= 1'b0;
      stall_left        <= 0;
    end else if (stall_left > 0) begin
      status_chan.ready <= 1'b0;
      stall_left        <= stall_left - 1;
    end else begin
      status_chan.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((event_chan.valid && event_chan.ready) || (status_chan.valid && status_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_event(input logic [1:0] mode, input logic [1:0] btn,
                            input logic [9:0] smp);
    int       gap;
    in_item_t ev;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      event_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev.mode    = mode;
    ev.buttons = btn;
    ev.sample  = smp;
    event_chan.data  <= ev;
    event_chan.valid <= 1'b1;
    do @(posedge clk); while (!(event_chan.valid && event_chan.ready));
  endtask

  task automatic press(input logic [1:0] btn);
    send_event(MODE_BUTTON, btn, 10'($urandom));
  endtask

  task automatic tick(input int n);
    repeat (n) send_event(MODE_TICK, 2'($urandom), 10'($urandom));
  endtask

  task automatic motion(input logic [9:0] smp);
    send_event(MODE_SAMPLE, 2'($urandom), smp);
  endtask

  task automatic enter_code();
    press(BTN_A);
    press(BTN_B);
    press(BTN_A);
    press(BTN_B);
  endtask

  // hold the sender until every status is back
  task automatic wait_drained();
    event_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_panel(input logic [15:0] exit_t, input logic [15:0] entry_t,
                           input logic [9:0] thr, input logic [2:0] tries);
    wait_drained();
    write_reg(REG_EXIT_TICKS, exit_t);
    write_reg(REG_ENTRY_TICKS, entry_t);
    write_reg(REG_THRESHOLD, {6'($urandom), thr});
    write_reg(REG_MAX_TRIES, {13'($urandom), tries});
    cfg_we <= 1'b0;
  endtask

  // random mix of codes, countdowns, motion, wrong digits and noise
  task automatic random_round(input int n_events);
    int taken;
    int r;
    int k;
    taken = 0;
    while (taken < n_events) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        enter_code();
        taken += 4;
      end else if (r < 55) begin
        k = $urandom_range(1, 10);
        tick(k);
        taken += k;
      end else if (r < 70) begin
        motion($urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 40)));
        taken++;
      end else if (r < 82) begin
        press(2'($urandom_range(1, 3)));
        taken++;
      end else if (r < 90) begin
        // correct prefix, then a wrong digit
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) press((i % 2 == 0) ? BTN_A : BTN_B);
        press($urandom_range(0, 1) ? BTN_BOTH : ((k % 2 == 0) ? BTN_B : BTN_A));
        taken += k + 1;
      end else if ($urandom_range(0, 1)) begin
        send_event(MODE_NONE, 2'($urandom), 10'($urandom));
        taken++;
      end else begin
        press(BTN_NONE);
        taken++;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_EXIT_TICKS;
    cfg_wdata         = '0;
    quiet             = 1'b0;
    event_chan.valid  = 1'b0;
    event_chan.data   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: events that change nothing while idle
    send_event(MODE_NONE, BTN_BOTH, 10'h3ff);
    press(BTN_NONE);
    tick(1);
    motion(10'd0);

    // wrong digits while idle, full cycle through to siren and back
    set_panel(16'd2, 16'd1, 10'd1023, 3'd7);
    press(BTN_A);
    press(BTN_A);
    press(BTN_B);
    press(BTN_BOTH);
    enter_code();
    motion(10'd0);
    tick(2);
    motion(10'd1023);
    motion(10'd1022);
    tick(1);
    press(BTN_BOTH);
    enter_code();
    enter_code();
    enter_code();

    // zero delays and zero tries, a threshold that never trips, then one that does
    set_panel(16'd0, 16'd0, 10'd0, 3'd0);
    enter_code();
    tick(1);
    motion(10'd0);
    press(BTN_BOTH);
    press(BTN_BOTH);
    tick(1);
    enter_code();
    set_panel(16'd0, 16'd0, 10'd5, 3'd0);
    enter_code();
    tick(1);
    motion(10'd4);
    tick(1);
    enter_code();

    // random rounds over several settings
    set_panel(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
              10'($urandom_range(10, 300)), 3'($urandom_range(1, 7)));
    random_round(ROUND_EVENTS);
    set_panel(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
              10'($urandom_range(10, 1023)), 3'($urandom_range(1, 7)));
    quiet <= 1'b1;
    random_round(ROUND_EVENTS);
    quiet <= 1'b0;
    set_panel(16'd1, 16'd1, 10'd1023, 3'd1);
    random_round(ROUND_EVENTS);
    set_panel(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
              10'($urandom_range(20, 60)), 3'($urandom_range(1, 7)));
    random_round(ROUND_EVENTS);

    // full exit countdown, then the longest entry delay cut short by the code
    set_panel(16'd20, 16'hffff, 10'd1023, 3'd7);
    quiet <= 1'b1;
    enter_code();
    tick(20);
    motion(10'd1022);
    tick(5);
    enter_code();
    quiet <= 1'b0;

    wait_drained();
    if (fail_count == 0 && pending_results == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
